### rtl/bole_pkg.sv
// shared widths, command codes and defaults for the bounded ordered list engine
`timescale 1ns / 1ps

package bole_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned CAPACITY_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

endpackage

### rtl/bole_mem.sv
// element storage: one write port, one read port with registered read data
`timescale 1ns / 1ps

module bole_mem #(
  parameter int unsigned DEPTH = bole_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bole_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [bole_pkg::DATA_W-1:0] rdata_o
);
  import bole_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bole_seq.sv
// command sequencer: ring pointers, delete shift and list dump
`timescale 1ns / 1ps

module bole_seq #(
  parameter int unsigned CAPACITY = bole_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bole_pkg::CMD_W-1:0]         command_i,
  input  logic signed [bole_pkg::DATA_W-1:0] item_value_i,
  input  logic [bole_pkg::POS_W-1:0]         position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bole_pkg::DATA_W-1:0] element_o,
  output logic                               last_o,
  output logic                               list_empty_o,
  output logic                               insert_dropped_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic [bole_pkg::DATA_W-1:0]        mem_wdata_o,
  output logic                               mem_re_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  logic [bole_pkg::DATA_W-1:0]        mem_rdata_i
);
  import bole_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DUMP
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] widx_q, widx_d;
  logic          wr_pend_q, wr_pend_d;
  logic          dropped_q, dropped_d;
  logic          out_valid_q, out_valid_d;
  logic          out_last_q, out_last_d;
  logic          out_empty_q, out_empty_d;
  logic          out_dropped_q, out_dropped_d;

  logic          accept;
  logic          out_free;
  logic [AW-1:0] head_dec;
  logic [CW-1:0] idx_inc;
  logic [XW-1:0] pos_x;

  // logical position to ring address
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                              input logic [CW-1:0] lidx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(lidx);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign head_dec   = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign idx_inc    = idx_q + CW'(1);
  assign pos_x      = XW'(position_i);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    widx_d        = widx_q;
    wr_pend_d     = 1'b0;
    dropped_d     = dropped_q;
    out_valid_d   = out_valid_q;
    out_last_d    = out_last_q;
    out_empty_d   = out_empty_q;
    out_dropped_d = out_dropped_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = ring_addr(head_q, count_q);
    mem_wdata_o   = item_value_i;
    mem_re_o      = 1'b0;
    mem_raddr_o   = ring_addr(head_q, idx_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dropped_d = 1'b0;
          idx_d     = '0;
          state_d   = ST_DUMP;
          unique case (command_i)
            CMD_FRONT: begin
              if (count_q == CAP_C) begin
                dropped_d = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = head_dec;
                head_d      = head_dec;
                count_d     = count_q + CW'(1);
              end
            end
            CMD_BACK: begin
              if (count_q == CAP_C) begin
                dropped_d = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            CMD_DELETE: begin
              if (pos_x < XW'(count_q)) begin
                idx_d   = CW'(pos_x + XW'(1));
                state_d = ST_SHIFT;
              end
            end
            CMD_DUMP: begin
              state_d = ST_DUMP;
            end
            default: begin
              state_d = ST_DUMP;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (wr_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ring_addr(head_q, widx_q);
          mem_wdata_o = mem_rdata_i;
        end
        if (idx_q < count_q) begin
          // read port data register doubles as the output word
          if (!out_valid_q) begin
            mem_re_o  = 1'b1;
            wr_pend_d = 1'b1;
            widx_d    = idx_q - CW'(1);
            idx_d     = idx_inc;
          end
        end else if (!wr_pend_q) begin
          count_d = count_q - CW'(1);
          idx_d   = '0;
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_dropped_d = dropped_q;
          if (count_q == '0) begin
            out_empty_d = 1'b1;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            out_empty_d = 1'b0;
            out_last_d  = (idx_inc == count_q);
            idx_d       = idx_inc;
            if (idx_inc == count_q) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      head_q        <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      widx_q        <= '0;
      wr_pend_q     <= 1'b0;
      dropped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
      out_empty_q   <= 1'b0;
      out_dropped_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      widx_q        <= widx_d;
      wr_pend_q     <= wr_pend_d;
      dropped_q     <= dropped_d;
      out_valid_q   <= out_valid_d;
      out_last_q    <= out_last_d;
      out_empty_q   <= out_empty_d;
      out_dropped_q <= out_dropped_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign element_o        = out_empty_q ? '0 : $signed(mem_rdata_i);
  assign last_o           = out_last_q;
  assign list_empty_o     = out_empty_q;
  assign insert_dropped_o = out_dropped_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("list count above capacity");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !wr_pend_q)
    else $error("shift write still pending while idle");

  a_rw_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write hit the same entry");

  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty word not marked last");

  a_read_into_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> out_free)
    else $error("read overwrites a word not yet taken");

endmodule

### rtl/bounded_ordered_list_engine_core.sv
// top level of the bounded ordered list engine: sequencer plus element memory
`timescale 1ns / 1ps

// Holds an ordered list of up to CAPACITY signed 32-bit values in a ring buffer
// inside one synchronous memory (one write port, one registered read port).
// Commands: insert front, append back, delete at a 0-based position, or dump
// only. Every command is followed by a dump of the whole list, front to back,
// one word per element with last set on the final word; an empty list gives a
// single word with list_empty set and element zero. An insert into a full list
// is dropped and every word of that dump carries insert_dropped. A delete at a
// position past the last element leaves the list alone. A command is taken
// while the sequencer is idle; insert front and append write the memory in
// the cycle the command is taken (the ring head moves for insert front, so no
// data moves). A delete at position p then slides the tail down through the
// memory, one entry per cycle while no output word is waiting, and then
// drains the last write when any entry moves. The dump then reads one entry
// per cycle while the output side is free, straight into the read data
// register that serves as the output word. The memory has no reset; the
// sequencer registers, head and count among them, are cleared, and no entry
// is read before it is written.
module bounded_ordered_list_engine_core #(
  parameter int unsigned CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bole_pkg::CMD_W-1:0]         command_i,
  input  logic signed [bole_pkg::DATA_W-1:0] item_value_i,
  input  logic [bole_pkg::POS_W-1:0]         position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bole_pkg::DATA_W-1:0] element_o,
  output logic                               last_o,
  output logic                               list_empty_o,
  output logic                               insert_dropped_o
);
  import bole_pkg::*;

  // ring address width
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // memory port between sequencer and storage
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // command decode, ring pointers, delete slide and dump sequencing
  bole_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_o        (element_o),
    .last_o           (last_o),
    .list_empty_o     (list_empty_o),
    .insert_dropped_o (insert_dropped_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  // element storage, read data held between reads
  bole_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
